// ----- src/psd_pkg.sv -----
`timescale 1ns / 1ps
package psd_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIST_BITS  = 17;

	typedef enum logic [1:0] {
		REG_INTERIOR = 2'd0,
		REG_START    = 2'd1,
		REG_END      = 2'd2,
		REG_DEGEN    = 2'd3
	} region_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
	} req_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] distance;
		region_t              region;
	} rsp_t;

endpackage

// ----- src/point_to_segment_distance.sv -----
`timescale 1ns / 1ps
// channel | handshake             | payload
// --------+-----------------------+-----------------------------------------
// request | req_valid / req_ready | req  : point, segment start, segment end
// result  | rsp_valid / rsp_ready | rsp  : distance, region
//
// one item per cycle unless the skid register is full; a request passes through
// 5 arithmetic stages, then 17 root stages, one distance bit each
// arst_n clears all valid bits; payload registers are not reset
// a stalled result goes to a skid register so the pipeline takes one more
// item, then the whole pipeline holds until the skid register drains
module point_to_segment_distance
	import psd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int DW = COORD_BITS + 1;   // coordinate difference
	localparam int PW = 2 * DW;           // product of two differences
	localparam int LW = PW + 1;           // sums of products
	localparam int HW = PW / 2;           // half of the cross magnitude
	localparam int NW = 2 * PW;           // squared cross
	localparam int RW = NW + 4;           // root remainder and terms

	logic pipe_en;
	logic skid_v_q;
	rsp_t skid_q;

	assign pipe_en   = !skid_v_q;
	assign req_ready = pipe_en;

	// stage 1: differences
	logic v_s1;
	logic signed [DW-1:0] ux_s1, uy_s1, vx_s1, vy_s1, wx_s1, wy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (pipe_en) v_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ux_s1 <= DW'(req.point_x) - DW'(req.start_x);
			uy_s1 <= DW'(req.point_y) - DW'(req.start_y);
			vx_s1 <= DW'(req.end_x) - DW'(req.start_x);
			vy_s1 <= DW'(req.end_y) - DW'(req.start_y);
			wx_s1 <= DW'(req.point_x) - DW'(req.end_x);
			wy_s1 <= DW'(req.point_y) - DW'(req.end_y);
		end
	end

	// stage 2: products
	logic v_s2;
	logic signed [PW-1:0] uxvx_s2, uyvy_s2, uxvy_s2, uyvx_s2;
	logic signed [PW-1:0] vxx_s2, vyy_s2, uxx_s2, uyy_s2, wxx_s2, wyy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (pipe_en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			uxvx_s2 <= ux_s1 * vx_s1;
			uyvy_s2 <= uy_s1 * vy_s1;
			uxvy_s2 <= ux_s1 * vy_s1;
			uyvx_s2 <= uy_s1 * vx_s1;
			vxx_s2  <= vx_s1 * vx_s1;
			vyy_s2  <= vy_s1 * vy_s1;
			uxx_s2  <= ux_s1 * ux_s1;
			uyy_s2  <= uy_s1 * uy_s1;
			wxx_s2  <= wx_s1 * wx_s1;
			wyy_s2  <= wy_s1 * wy_s1;
		end
	end

	// stage 3: dot, cross and squared lengths
	logic v_s3;
	logic signed [LW-1:0] dot_s3, cross_s3;
	logic [LW-1:0] len2_s3, su_s3, sw_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (pipe_en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			dot_s3   <= LW'(uxvx_s2) + LW'(uyvy_s2);
			cross_s3 <= LW'(uxvy_s2) - LW'(uyvx_s2);
			len2_s3  <= LW'(vxx_s2) + LW'(vyy_s2);
			su_s3    <= LW'(uxx_s2) + LW'(uyy_s2);
			sw_s3    <= LW'(wxx_s2) + LW'(wyy_s2);
		end
	end

	// stage 4: region, cross squared as partial products
	logic v_s4;
	region_t reg_s4;
	logic [LW-1:0] nsm_s4, len2_s4;
	logic [PW-1:0] hh_s4, hl_s4, ll_s4;

	logic [LW-1:0] cmag;
	logic [HW-1:0] chi, clo;
	region_t reg_c;

	always_comb begin
		cmag = cross_s3[LW-1] ? LW'(-cross_s3) : LW'(cross_s3);
		chi  = cmag[PW-1:HW];
		clo  = cmag[HW-1:0];
		if (len2_s3 == '0) reg_c = REG_DEGEN;
		else if (dot_s3[LW-1]) reg_c = REG_START;
		else if ($signed({1'b0, dot_s3}) > $signed({1'b0, len2_s3})) reg_c = REG_END;
		else reg_c = REG_INTERIOR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (pipe_en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			reg_s4  <= reg_c;
			nsm_s4  <= (reg_c == REG_END) ? sw_s3 : su_s3;
			len2_s4 <= len2_s3;
			hh_s4   <= chi * chi;
			hl_s4   <= chi * clo;
			ll_s4   <= clo * clo;
		end
	end

	// stage 5: numerator and denominator of the root search
	logic v_s5;
	region_t reg_s5;
	logic [NW-1:0] n_s5;
	logic [LW-1:0] den_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (pipe_en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			reg_s5 <= reg_s4;
			if (reg_s4 == REG_INTERIOR) begin
				n_s5   <= (NW'(hh_s4) << (2 * HW)) + (NW'(hl_s4) << (HW + 1)) + NW'(ll_s4);
				den_s5 <= len2_s4;
			end else begin
				n_s5   <= NW'(nsm_s4);
				den_s5 <= LW'(1);
			end
		end
	end

	// root stages: largest d with d*d*den <= n, one bit per stage
	logic                 rt_v_s   [DIST_BITS];
	region_t              rt_reg_s [DIST_BITS];
	logic [RW-1:0]        rt_rem_s [DIST_BITS];
	logic [RW-1:0]        rt_dd_s  [DIST_BITS];
	logic [LW-1:0]        rt_den_s [DIST_BITS];
	logic [DIST_BITS-1:0] rt_d_s   [DIST_BITS];

	for (genvar k = 0; k < DIST_BITS; k++) begin : g_root
		localparam int B = DIST_BITS - 1 - k;
		logic                 v_in;
		region_t              reg_in;
		logic [RW-1:0]        rem_in, dd_in, term;
		logic [LW-1:0]        den_in;
		logic [DIST_BITS-1:0] d_in;

		if (k == 0) begin : g_first
			assign v_in   = v_s5;
			assign reg_in = reg_s5;
			assign rem_in = RW'(n_s5);
			assign dd_in  = '0;
			assign den_in = den_s5;
			assign d_in   = '0;
		end else begin : g_next
			assign v_in   = rt_v_s[k-1];
			assign reg_in = rt_reg_s[k-1];
			assign rem_in = rt_rem_s[k-1];
			assign dd_in  = rt_dd_s[k-1];
			assign den_in = rt_den_s[k-1];
			assign d_in   = rt_d_s[k-1];
		end

		// (d + 2^b)^2 den - d^2 den, with dd holding d*den
		assign term = (dd_in << (B + 1)) + (RW'(den_in) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_v_s[k] <= 1'b0;
			else if (pipe_en) rt_v_s[k] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				rt_reg_s[k] <= reg_in;
				rt_den_s[k] <= den_in;
				if (term <= rem_in) begin
					rt_rem_s[k] <= rem_in - term;
					rt_dd_s[k]  <= dd_in + (RW'(den_in) << B);
					rt_d_s[k]   <= d_in | (DIST_BITS'(1) << B);
				end else begin
					rt_rem_s[k] <= rem_in;
					rt_dd_s[k]  <= dd_in;
					rt_d_s[k]   <= d_in;
				end
			end
		end
	end

	// output skid
	rsp_t last_rsp;
	logic last_v;

	assign last_v            = rt_v_s[DIST_BITS-1];
	assign last_rsp.distance = rt_d_s[DIST_BITS-1];
	assign last_rsp.region   = rt_reg_s[DIST_BITS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) skid_v_q <= 1'b0;
		else if (skid_v_q) begin
			if (rsp_ready) skid_v_q <= 1'b0;
		end else if (last_v && !rsp_ready) skid_v_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q) skid_q <= last_rsp;
	end

	assign rsp_valid = skid_v_q || last_v;
	assign rsp       = skid_v_q ? skid_q : last_rsp;

	// the root search never sees a zero denominator
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> den_s5 != '0)
		else $error("zero denominator entering root search");

	// end-point distances stay within the squared-length range
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && reg_s5 != REG_INTERIOR) |-> (n_s5 >> LW) == '0 && den_s5 == LW'(1))
		else $error("end-point numerator out of range");

	// a held skid item stays until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !rsp_ready) |=> skid_v_q && $stable(skid_q))
		else $error("skid item lost");

	// the pipeline is frozen while the skid register is full
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |=> $stable(rt_d_s[DIST_BITS-1]) || !$past(last_v))
		else $error("pipeline moved under a full skid");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import psd_pkg::*;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	point_to_segment_distance dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	req_t pending_q[$];
	rsp_t expected_q[$];
	int mismatches;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_send;
	bit stim_done;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint sq(longint v);
		return v * v;
	endfunction

	// largest d in 17 bits with d*d*den <= num (num up to ~2^66 in interior case)
	function automatic logic [DIST_BITS-1:0] floor_root(logic [79:0] num, logic [79:0] den);
		logic [DIST_BITS-1:0] d;
		logic [DIST_BITS-1:0] c;
		logic [113:0] lhs;
		d = '0;
		for (int b = DIST_BITS - 1; b >= 0; b--) begin
			c = d | (17'd1 << b);
			lhs = 114'(c) * 114'(c) * 114'(den);
			if (lhs <= 114'(num))
				d = c;
		end
		return d;
	endfunction

	function automatic rsp_t segment_distance(req_t q);
		longint px, py, sx, sy, ex, ey, ux, uy, vx, vy, len2, dotp, crossp;
		logic [79:0] cmag;
		rsp_t r;
		px = q.point_x; py = q.point_y;
		sx = q.start_x; sy = q.start_y;
		ex = q.end_x;   ey = q.end_y;
		ux = px - sx; uy = py - sy;
		vx = ex - sx; vy = ey - sy;
		len2 = sq(vx) + sq(vy);
		dotp = ux * vx + uy * vy;
		if (len2 == 0) begin
			r.region = REG_DEGEN;
			r.distance = floor_root(80'(sq(ux) + sq(uy)), 80'd1);
		end else if (dotp < 0) begin
			r.region = REG_START;
			r.distance = floor_root(80'(sq(ux) + sq(uy)), 80'd1);
		end else if (dotp > len2) begin
			r.region = REG_END;
			r.distance = floor_root(80'(sq(px - ex) + sq(py - ey)), 80'd1);
		end else begin
			crossp = ux * vy - uy * vx;
			if (crossp < 0)
				crossp = -crossp;
			cmag = 80'(crossp) * 80'(crossp);
			r.region = REG_INTERIOR;
			r.distance = floor_root(cmag, 80'(len2));
		end
		return r;
	endfunction

	task automatic report(string what, rsp_t got, rsp_t want);
		$display("mismatch %s: got dist %0d region %0d, want dist %0d region %0d",
			what, got.distance, got.region, want.distance, want.region);
		mismatches++;
	endtask

	function automatic logic signed [15:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($urandom_range(0, 40)) - 16'sd20;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic req_t mk(int px, int py, int sx, int sy, int ex, int ey);
		req_t q;
		q.point_x = 16'(px); q.point_y = 16'(py);
		q.start_x = 16'(sx); q.start_y = 16'(sy);
		q.end_x = 16'(ex);   q.end_y = 16'(ey);
		return q;
	endfunction

	// driver: the front of the queue is the item on the bus until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && req_ready) begin
				expected_q.push_back(segment_distance(req));
				void'(pending_q.pop_front());
			end
			if (req_valid && !req_ready) begin
				// hold the item
			end else if (pending_q.size() != 0 && !hold_send
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				req_valid <= 1'b1;
				req <= pending_q[0];
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected item", rsp, '0);
				end else begin
					if (rsp.distance !== expected_q[0].distance)
						report("distance", rsp, expected_q[0]);
					else if (rsp.region !== expected_q[0].region)
						report("region", rsp, expected_q[0]);
					void'(expected_q.pop_front());
				end
			end
			rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic wait_sent();
		while (pending_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_items(int n);
		req_t q;
		for (int i = 0; i < n; i++) begin
			q = mk(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), rand_coord());
			case ($urandom_range(0, 9))
				0: begin q.end_x = q.start_x; q.end_y = q.start_y; end
				1: begin q.point_x = q.start_x + 16'($urandom_range(0, 2)) - 16'sd1; end
				2: begin q.point_x = q.end_x; q.point_y = q.end_y; end
				default: ;
			endcase
			pending_q.push_back(q);
		end
	endtask

	initial begin
		mismatches = 0;
		hold_send = 1'b0;
		stim_done = 1'b0;
		send_idle_pct = 16;
		recv_idle_pct = 63;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, each region, ends exactly, degenerate
		pending_q.push_back(mk(0, 5, -10, 0, 10, 0));
		pending_q.push_back(mk(-20, 3, -10, 0, 10, 0));
		pending_q.push_back(mk(20, -4, -10, 0, 10, 0));
		pending_q.push_back(mk(-10, 7, -10, 0, 10, 0));
		pending_q.push_back(mk(10, 7, -10, 0, 10, 0));
		pending_q.push_back(mk(3, 4, 1, 1, 1, 1));
		pending_q.push_back(mk(-32768, -32768, 32767, 32767, 32767, 32767));
		pending_q.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767));
		pending_q.push_back(mk(32767, -32768, -32768, 32767, 32767, 32767));
		pending_q.push_back(mk(-32768, 32767, -32768, -32768, 32767, 32767));
		pending_q.push_back(mk(32767, -32768, -32768, -32768, 32767, 32767));
		pending_q.push_back(mk(-32768, -32768, -32768, 32767, 32767, -32768));
		pending_q.push_back(mk(0, 0, 0, 0, 0, 0));
		pending_q.push_back(mk(-1, -1, -1, -1, -1, -1));
		pending_q.push_back(mk(5, 5, 0, 0, 3, 3));
		pending_q.push_back(mk(1, 0, 0, 0, 3, 7));
		random_items(420);
		wait_sent();

		// pause until every result is back
		hold_send = 1'b1;
		while (expected_q.size() != 0 || req_valid)
			@(posedge clk);
		hold_send = 1'b0;

		send_idle_pct = 63;
		recv_idle_pct = 16;
		random_items(430);
		wait_sent();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_items(430);
		wait_sent();

		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
